### rtl/imufp_pkg.sv
// Shared types and constants for the IMU frame parser and decoder.
`default_nettype none

package imufp_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN    = 11;
    localparam int unsigned PAYLOAD_LEN  = FRAME_LEN - 1;
    localparam logic [3:0]  CHECKSUM_POS = 4'(FRAME_LEN - 1);
    localparam int unsigned NUM_WORDS    = 4;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    // Scaling: value = raw * coef * 2^F / 2^shift, temperature = raw * 2^F / 100
    localparam logic [7:0] COEF_ACCEL  = 8'd125;
    localparam logic [7:0] COEF_GYRO   = 8'd125;
    localparam logic [7:0] COEF_ANGLE  = 8'd180;
    localparam logic [3:0] SHIFT_ACCEL = 4'd8;
    localparam logic [3:0] SHIFT_GYRO  = 4'd11;
    localparam logic [3:0] SHIFT_ANGLE = 4'd15;
    localparam longint unsigned TEMP_DIV = 100;

    // Signed 24-bit limits
    localparam logic [23:0] VAL_MAX     = 24'h7F_FFFF;
    localparam logic [23:0] VAL_MIN     = 24'h80_0000;
    localparam logic [23:0] NEG_MAG_MAX = 24'h80_0000;

    typedef enum logic [2:0] {
        KIND_ACCEL   = 3'd0,
        KIND_GYRO    = 3'd1,
        KIND_ANGLE   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_BAD     = 3'd4
    } frame_kind_t;

    // One classified frame, as queued between front and back
    typedef struct packed {
        frame_kind_t       kind;
        logic [3:0][15:0]  words;
    } frame_rec_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### rtl/imu_frame_parser_decoder_top.sv
// Top level of the IMU frame parser and decoder.
// Throughput: one byte transfer per cycle; one result per completed 11-byte frame.
// The checksum byte transfer pushes the classified frame into the frame queue; the back end
// then scales the queue head into the output register, which holds while the output stalls.
// The input stalls only while the two-entry frame queue is full.
// Reset clears frame position, running sum, queue and output valid; frame bytes are not reset.
`default_nettype none

module imu_frame_parser_decoder_top
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          burst_start,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         frame_kind,
    output logic signed [23:0] value_x,
    output logic signed [23:0] value_y,
    output logic signed [23:0] value_z,
    output logic signed [23:0] value_extra
);

    logic                     push;
    logic                     pop;
    imufp_pkg::frame_rec_t    push_rec;
    imufp_pkg::frame_rec_t    head_rec;
    imufp_pkg::queue_status_t q_status;

    imufp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .rx_byte     (rx_byte),
        .burst_start (burst_start),
        .q_status    (q_status),
        .in_stall    (in_stall),
        .push        (push),
        .push_rec    (push_rec)
    );

    imufp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    imufp_back
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_rec    (head_rec),
        .q_status    (q_status),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_valid   (out_valid),
        .frame_kind  (frame_kind),
        .value_x     (value_x),
        .value_y     (value_y),
        .value_z     (value_z),
        .value_extra (value_extra)
    );

endmodule

`default_nettype wire

### rtl/imufp_front.sv
// Front end: byte framing, running checksum and frame classification.
`default_nettype none

module imufp_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  burst_start,
    input  wire imufp_pkg::queue_status_t q_status,
    output logic                       in_stall,
    output logic                       push,
    output imufp_pkg::frame_rec_t      push_rec
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] frame_bytes_reg [imufp_pkg::PAYLOAD_LEN];

    logic       accept;
    logic [3:0] pos_eff;
    logic [7:0] sum_eff;
    logic       is_last;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // Burst start or an impossible position restarts framing
    always_comb
    begin
        if (burst_start || (pos_reg > imufp_pkg::CHECKSUM_POS))
        begin
            pos_eff = 4'd0;
            sum_eff = 8'd0;
        end
        else
        begin
            pos_eff = pos_reg;
            sum_eff = sum_reg;
        end
        is_last = (pos_eff == imufp_pkg::CHECKSUM_POS);
    end

    // Next framing state
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (is_last)
            begin
                pos_next = 4'd0;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = pos_eff + 4'd1;
                sum_next = sum_eff + rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Frame byte store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && !is_last)
        begin
            frame_bytes_reg[pos_eff] <= rx_byte;
        end
    end

    // Classify on the checksum byte
    always_comb
    begin
        push = accept && is_last;
        for (int i = 0; i < imufp_pkg::NUM_WORDS; i++)
        begin
            push_rec.words[i] = {frame_bytes_reg[2*i+3], frame_bytes_reg[2*i+2]};
        end
        if ((frame_bytes_reg[0] != imufp_pkg::HEADER_BYTE) || (sum_eff != rx_byte))
        begin
            push_rec.kind = imufp_pkg::KIND_BAD;
        end
        else if (frame_bytes_reg[1] == imufp_pkg::TYPE_ACCEL)
        begin
            push_rec.kind = imufp_pkg::KIND_ACCEL;
        end
        else if (frame_bytes_reg[1] == imufp_pkg::TYPE_GYRO)
        begin
            push_rec.kind = imufp_pkg::KIND_GYRO;
        end
        else if (frame_bytes_reg[1] == imufp_pkg::TYPE_ANGLE)
        begin
            push_rec.kind = imufp_pkg::KIND_ANGLE;
        end
        else
        begin
            push_rec.kind = imufp_pkg::KIND_UNKNOWN;
        end
    end

endmodule

`default_nettype wire

### rtl/imufp_queue.sv
// Two-entry frame queue between the front and back ends.
`default_nettype none

module imufp_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire imufp_pkg::frame_rec_t push_rec,
    input  wire logic                  pop,
    output imufp_pkg::frame_rec_t      head_rec,
    output imufp_pkg::queue_status_t   status
);

    imufp_pkg::frame_rec_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

### rtl/imufp_back.sv
// Back end: fixed-point scaling of a queued frame into the output register.
`default_nettype none

module imufp_back
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire imufp_pkg::frame_rec_t    head_rec,
    input  wire imufp_pkg::queue_status_t q_status,
    input  wire logic                     out_stall,
    output logic                          pop,
    output logic                          out_valid,
    output logic [2:0]                    frame_kind,
    output logic signed [23:0]            value_x,
    output logic signed [23:0]            value_y,
    output logic signed [23:0]            value_z,
    output logic signed [23:0]            value_extra
);

    // Magnitude width after coef multiply and fraction shift
    localparam int MAGW = 16 + 8 + FRAC_BITS;
    // Temperature reciprocal: exact floor(a / 100) for a < 2^NT
    localparam int NT = 16 + FRAC_BITS;
    localparam int ST = NT + 7;
    localparam int TW = 2 * NT + 1;
    localparam longint unsigned MT_L =
        ((64'd1 << ST) + imufp_pkg::TEMP_DIV - 64'd1) / imufp_pkg::TEMP_DIV;
    localparam logic [NT:0] MT = (NT+1)'(MT_L);

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [23:0] val_reg [4];

    logic        load;
    logic [7:0]  coef;
    logic [3:0]  shamt;
    logic [23:0] lane_val [3];
    logic [23:0] temp_val;
    logic [23:0] vers_val;
    logic [23:0] val_next [4];

    logic [15:0]     lane_abs [3];
    logic [23:0]     lane_prod [3];
    logic [MAGW-1:0] lane_mag [3];
    logic [15:0]     t_abs;
    logic [NT-1:0]   t_num;
    logic [TW-1:0]   t_prod;
    logic [MAGW-1:0] t_mag;

    // Truncated magnitude plus sign to saturated two's complement
    function automatic logic [23:0] sat_val(input logic [MAGW-1:0] mag, input logic neg);
        logic [23:0] res;
        if (neg)
        begin
            if (mag > MAGW'(imufp_pkg::NEG_MAG_MAX))
                res = imufp_pkg::VAL_MIN;
            else
                res = 24'(-mag[23:0]);
        end
        else
        begin
            if (mag > MAGW'(imufp_pkg::VAL_MAX))
                res = imufp_pkg::VAL_MAX;
            else
                res = mag[23:0];
        end
        return res;
    endfunction

    assign load = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load;

    // Per-kind scale constants
    always_comb
    begin
        unique case (head_rec.kind)
            imufp_pkg::KIND_ACCEL:
            begin
                coef  = imufp_pkg::COEF_ACCEL;
                shamt = imufp_pkg::SHIFT_ACCEL;
            end
            imufp_pkg::KIND_GYRO:
            begin
                coef  = imufp_pkg::COEF_GYRO;
                shamt = imufp_pkg::SHIFT_GYRO;
            end
            default:
            begin
                coef  = imufp_pkg::COEF_ANGLE;
                shamt = imufp_pkg::SHIFT_ANGLE;
            end
        endcase
    end

    // Axis lanes: one multiply each, then power-of-two shift
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_abs[i]  = head_rec.words[i][15] ? 16'(-head_rec.words[i])
                                                 : head_rec.words[i];
            lane_prod[i] = 24'(lane_abs[i]) * 24'(coef);
            lane_mag[i]  = (MAGW'(lane_prod[i]) << FRAC_BITS) >> shamt;
            lane_val[i]  = sat_val(lane_mag[i], head_rec.words[i][15]);
        end
    end

    // Fourth word: temperature by reciprocal multiply, or raw version
    always_comb
    begin
        t_abs    = head_rec.words[3][15] ? 16'(-head_rec.words[3]) : head_rec.words[3];
        t_num    = NT'(t_abs) << FRAC_BITS;
        t_prod   = TW'(t_num) * TW'(MT);
        t_mag    = MAGW'(t_prod >> ST);
        temp_val = sat_val(t_mag, head_rec.words[3][15]);
        vers_val = {{8{head_rec.words[3][15]}}, head_rec.words[3]};
    end

    // Result selection by kind
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            val_next[i] = 24'd0;
        end
        unique case (head_rec.kind)
            imufp_pkg::KIND_ACCEL:
            begin
                for (int i = 0; i < 3; i++)
                    val_next[i] = lane_val[i];
                val_next[3] = temp_val;
            end
            imufp_pkg::KIND_GYRO:
            begin
                for (int i = 0; i < 3; i++)
                    val_next[i] = lane_val[i];
            end
            imufp_pkg::KIND_ANGLE:
            begin
                for (int i = 0; i < 3; i++)
                    val_next[i] = lane_val[i];
                val_next[3] = vers_val;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head_rec.kind;
            for (int i = 0; i < 4; i++)
                val_reg[i] <= val_next[i];
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_kind  = kind_reg;
    assign value_x     = $signed(val_reg[0]);
    assign value_y     = $signed(val_reg[1]);
    assign value_z     = $signed(val_reg[2]);
    assign value_extra = $signed(val_reg[3]);

endmodule

`default_nettype wire
